@@ src/bucketed_hash_table_insert_search_defines.svh @@
// Assertion macros for the hash table block
`ifndef BUCKETED_HASH_TABLE_INSERT_SEARCH_DEFINES_SVH
`define BUCKETED_HASH_TABLE_INSERT_SEARCH_DEFINES_SVH
`ifndef ASSERT_OFF
`define BHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BHT_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BHT_ASSERT(label, clk, rst, prop, msg)
`define BHT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ src/bht_pkg.sv @@
`default_nettype none
package bht_pkg;
   localparam int KEY_W   = 52;
   localparam int NF_W    = 64;
   localparam int NR_W    = 48;
   localparam int CFG_W   = 6;
   localparam int DIGITS  = 13;
   localparam int SUM_W   = 16;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_PRESENT   = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   localparam logic [1:0] REG_MODULUS = 2'd0;
   localparam logic [1:0] REG_BLOCKS  = 2'd1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_MOD, S_RING, S_READ, S_WAIT, S_SCAN, S_WRITE, S_OUT
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic hash;
      logic mod_step;
      logic ring_step;
      logic rd;
      logic scan_step;
      logic next_blk;
      logic wr;
      logic set_out;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic mod_done;
      logic ring_done;
      logic slot_hit;
      logic slot_empty;
      logic last_slot;
      logic lap_done;
   } sts_type;

   function automatic logic [3:0] digit(input logic [KEY_W-1:0] k, input int d);
      return k[4*(DIGITS-1-d) +: 4];
   endfunction

   // nibbles above 9 count at face value, so one group reaches 16665
   function automatic logic [14:0] four(input logic [3:0] a, input logic [3:0] b,
                                        input logic [3:0] c, input logic [3:0] e);
      return 15'(a) * 15'd1000 + 15'(b) * 15'd100 + 15'(c) * 15'd10 + 15'(e);
   endfunction
endpackage
`default_nettype wire

@@ src/bht_ctrl.sv @@
`default_nettype none
module bht_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_beat,
   input  wire logic             is_search,
   input  wire logic             out_free,
   input  wire bht_pkg::sts_type sts,
   output bht_pkg::cmd_type      cmd,
   output logic                  busy
);
   import bht_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            busy = 1'b0;
            if (in_beat) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash = 1'b1;
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) state_in = S_RING;
         end
         S_RING: begin
            cmd.ring_step = 1'b1;
            if (sts.ring_done) state_in = S_READ;
         end
         S_READ: begin
            cmd.rd = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: state_in = S_SCAN;
         S_SCAN: begin
            if (sts.slot_hit) begin
               state_in = S_OUT;
            end else if (sts.slot_empty) begin
               state_in = is_search ? S_OUT : S_WRITE;
            end else if (sts.last_slot) begin
               cmd.next_blk = 1'b1;
               state_in = sts.lap_done ? S_OUT : S_READ;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_WRITE: begin
            cmd.wr = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.set_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ src/bht_dpath.sv @@
`default_nettype none
module bht_dpath #(
   parameter int NUM_BLOCKS      = 32,
   parameter int SLOTS_PER_BLOCK = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bht_pkg::cmd_type         cmd,
   output bht_pkg::sts_type              sts,
   input  wire logic                     req_kind,
   input  wire logic [bht_pkg::KEY_W-1:0] req_key,
   input  wire logic [bht_pkg::NF_W-1:0]  req_nf,
   input  wire logic [bht_pkg::NR_W-1:0]  req_nr,
   input  wire logic [bht_pkg::CFG_W-1:0] modulus,
   input  wire logic [bht_pkg::CFG_W-1:0] blocks,
   output logic                          kind,
   output logic [2:0]                    res_status,
   output logic [4:0]                    res_block,
   output logic [3:0]                    res_slot,
   output logic [bht_pkg::NF_W-1:0]      res_nf,
   output logic [bht_pkg::NR_W-1:0]      res_nr
);
   import bht_pkg::*;

   localparam int BLK_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int SLT_W   = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
   localparam int TOTAL   = NUM_BLOCKS * SLOTS_PER_BLOCK;
   localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int RING_W  = $clog2(NUM_BLOCKS + 1) > CFG_W ? $clog2(NUM_BLOCKS + 1) : CFG_W;
   localparam int DEN_W   = SUM_W + RING_W;

   // one row per block: valid bits, keys and names kept in separate memories
   logic [SLOTS_PER_BLOCK-1:0] valid_mem [NUM_BLOCKS];
   logic [KEY_W-1:0]           key_mem   [TOTAL];
   logic [NF_W-1:0]            nf_mem    [TOTAL];
   logic [NR_W-1:0]            nr_mem    [TOTAL];

   logic                       kind_ff;
   logic [KEY_W-1:0]           key_ff;
   logic [NF_W-1:0]            nf_ff;
   logic [NR_W-1:0]            nr_ff;
   logic [SUM_W-1:0]           rem_ff;
   logic [3:0]                 sh_ff;
   logic [RING_W-1:0]          ring_ff;
   logic [BLK_W-1:0]           start_ff, blk_ff, clr_ff;
   logic [SLT_W-1:0]           slot_ff;
   logic [SLOTS_PER_BLOCK-1:0] vrow_ff;
   logic [KEY_W-1:0]           rkey_ff;
   logic [NF_W-1:0]            rnf_ff;
   logic [NR_W-1:0]            rnr_ff;
   logic [2:0]                 status_ff;

   logic [CFG_W-1:0]  mod_eff;
   logic [RING_W-1:0] ring_eff;
   logic [ADDR_W-1:0] addr;
   logic [SLT_W-1:0]  slot_rd;
   logic [ADDR_W-1:0] rd_addr;
   logic              at_last_blk;
   logic [RING_W-1:0] divisor;
   logic [DEN_W-1:0]  den;
   logic [SUM_W-1:0]  rem_sub;

   assign mod_eff = (modulus == '0) ? CFG_W'(1) : modulus;
   always_comb begin
      if (blocks == '0) ring_eff = RING_W'(1);
      else if (RING_W'(blocks) > RING_W'(NUM_BLOCKS)) ring_eff = RING_W'(NUM_BLOCKS);
      else ring_eff = RING_W'(blocks);
   end

   assign addr = ADDR_W'(blk_ff) * ADDR_W'(SLOTS_PER_BLOCK) + ADDR_W'(slot_ff);
   // read one slot ahead while scanning so the key is ready in the next cycle
   assign slot_rd = cmd.scan_step ? slot_ff + SLT_W'(1) : slot_ff;
   assign rd_addr = ADDR_W'(blk_ff) * ADDR_W'(SLOTS_PER_BLOCK) + ADDR_W'(slot_rd);
   assign at_last_blk = (RING_W'(blk_ff) + RING_W'(1)) >= ring_ff;

   // shift-and-subtract remainder, one quotient bit per cycle
   assign divisor = cmd.ring_step ? ring_ff : RING_W'(mod_eff);
   assign den     = DEN_W'(divisor) << sh_ff;
   assign rem_sub = (DEN_W'(rem_ff) >= den) ? rem_ff - SUM_W'(den) : rem_ff;

   assign sts.clr_done   = (clr_ff == BLK_W'(NUM_BLOCKS - 1));
   assign sts.mod_done   = (sh_ff == 4'd0);
   assign sts.ring_done  = (sh_ff == 4'd0);
   assign sts.slot_hit   = vrow_ff[slot_ff] && (rkey_ff == key_ff);
   assign sts.slot_empty = !vrow_ff[slot_ff];
   assign sts.last_slot  = (slot_ff == SLT_W'(SLOTS_PER_BLOCK - 1));
   assign sts.lap_done   = (at_last_blk ? BLK_W'(0) : blk_ff + BLK_W'(1)) == start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         valid_mem[clr_ff] <= '0;
         clr_ff <= clr_ff + BLK_W'(1);
      end else if (cmd.wr) begin
         valid_mem[blk_ff] <= vrow_ff | (SLOTS_PER_BLOCK'(1) << slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         key_mem[addr] <= key_ff;
         nf_mem[addr]  <= nf_ff;
         nr_mem[addr]  <= nr_ff;
      end
      if (cmd.rd) vrow_ff <= valid_mem[blk_ff];
      rkey_ff <= key_mem[rd_addr];
      rnf_ff  <= nf_mem[rd_addr];
      rnr_ff  <= nr_mem[rd_addr];
   end

   // sum < 50000 < modulus << 16; after the modulus, rem < 64 <= ring << 6
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff  <= req_key;
         nf_ff   <= req_nf;
         nr_ff   <= req_nr;
         ring_ff <= ring_eff;
      end
      if (cmd.hash) begin
         rem_ff <= SUM_W'(four(digit(key_ff,4), digit(key_ff,5), digit(key_ff,6),
                               digit(key_ff,7)))
                 + SUM_W'(four(digit(key_ff,3), digit(key_ff,2), digit(key_ff,1),
                               digit(key_ff,0)))
                 + SUM_W'(four(digit(key_ff,11), digit(key_ff,10), digit(key_ff,9),
                               digit(key_ff,8)));
         sh_ff  <= 4'd15;
      end else if (cmd.mod_step) begin
         rem_ff <= rem_sub;
         sh_ff  <= sts.mod_done ? 4'd5 : sh_ff - 4'd1;
      end else if (cmd.ring_step) begin
         rem_ff <= rem_sub;
         sh_ff  <= sh_ff - 4'd1;
         if (sts.ring_done) begin
            start_ff <= BLK_W'(rem_sub);
            blk_ff   <= BLK_W'(rem_sub);
            slot_ff  <= '0;
         end
      end
      if (cmd.scan_step) slot_ff <= slot_ff + SLT_W'(1);
      if (cmd.next_blk) begin
         slot_ff <= '0;
         blk_ff  <= at_last_blk ? BLK_W'(0) : blk_ff + BLK_W'(1);
      end
      if (cmd.rd) slot_ff <= '0;
   end

   // result held for the output stage
   always_ff @(posedge clock) begin
      if (cmd.load) status_ff <= req_kind ? ST_NOT_FOUND : ST_FULL;
      else if (sts.slot_hit && !cmd.next_blk && !cmd.scan_step && !cmd.rd
               && !cmd.wr && status_ff != ST_FOUND && status_ff != ST_PRESENT
               && status_ff != ST_INSERTED && vrow_ff[slot_ff] && !cmd.set_out
               && !cmd.mod_step && !cmd.ring_step && !cmd.hash)
         status_ff <= kind_ff ? ST_FOUND : ST_PRESENT;
      else if (cmd.wr) status_ff <= ST_INSERTED;
   end

   assign kind       = kind_ff;
   assign res_status = status_ff;
   assign res_block  = (status_ff == ST_FULL || status_ff == ST_NOT_FOUND) ? 5'd0 : 5'(blk_ff);
   assign res_slot   = (status_ff == ST_FULL || status_ff == ST_NOT_FOUND) ? 4'd0 : 4'(slot_ff);
   assign res_nf     = (status_ff == ST_FOUND) ? rnf_ff : '0;
   assign res_nr     = (status_ff == ST_FOUND) ? rnr_ff : '0;
endmodule
`default_nettype wire

@@ src/bucketed_hash_table_insert_search.sv @@
// Bucketed hash table, insert and search by 13-digit BCD key.
// Request channel req_*: one beat per request (insert or search), accepted
// when req_tvalid and req_tready are high; req_tready is high only when the
// block is idle, one request is in work at a time.
// Response channel rsp_*: exactly one beat per request, held in an output
// register until taken; a stalled receiver holds the block after the next
// request is done.
// Steps: a digit sum, a shift-and-subtract remainder by the modulus and
// then by the ring size, then per probed block a row read and a scan of
// the slots, a write for an insert, and a load of the output register.
// Reset clears control state, loads the registers with 23 and 26, and runs
// a clearing pass over every valid row, during which no request is
// accepted. Config via csr_* APB port while idle.
`default_nettype none
`include "bucketed_hash_table_insert_search_defines.svh"
module bucketed_hash_table_insert_search #(
   parameter int NUM_BLOCKS      = 32,
   parameter int SLOTS_PER_BLOCK = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [167:0] req_tdata,  // key_bcd, name_first, name_rest
   input  wire logic         req_tuser,  // req_type
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,  // block_index, slot_index, names
   output logic [2:0]        rsp_tuser,  // status
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import bht_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic busy, kind;
   logic [CFG_W-1:0] mod_ff, blk_ff;
   logic rsp_valid_ff;
   logic [127:0] rsp_data_ff;
   logic [2:0] rsp_user_ff;
   logic [2:0] st;
   logic [4:0] rb;
   logic [3:0] rs;
   logic [NF_W-1:0] rnf;
   logic [NR_W-1:0] rnr;
   logic wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx = {1'b0, csr_paddr[2]};
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= CFG_W'(23);
         blk_ff <= CFG_W'(26);
      end else if (wr_en && csr_paddr[1:0] == 2'b00) begin
         if (reg_idx == REG_MODULUS) mod_ff <= csr_pwdata[CFG_W-1:0];
         else if (reg_idx == REG_BLOCKS) blk_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODULUS: csr_prdata = 32'(mod_ff);
         REG_BLOCKS:  csr_prdata = 32'(blk_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign req_tready = !busy;

   bht_ctrl u_ctrl (
      .clock, .reset,
      .in_beat   (req_tvalid && req_tready),
      .is_search (kind),
      .out_free  (!rsp_valid_ff || rsp_tready),
      .sts, .cmd, .busy
   );

   bht_dpath #(.NUM_BLOCKS(NUM_BLOCKS), .SLOTS_PER_BLOCK(SLOTS_PER_BLOCK)) u_dpath (
      .clock, .reset, .cmd, .sts,
      .req_kind (req_tuser),
      .req_key  (req_tdata[51:0]),
      .req_nf   (req_tdata[115:52]),
      .req_nr   (req_tdata[163:116]),
      .modulus  (mod_ff),
      .blocks   (blk_ff),
      .kind,
      .res_status (st), .res_block (rb), .res_slot (rs),
      .res_nf (rnf), .res_nr (rnr)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.set_out) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.set_out) begin
         rsp_data_ff <= {7'd0, rnr, rnf, rs, rb};
         rsp_user_ff <= st;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `BHT_ASSERT(a_no_accept_busy, clock, reset, busy |-> !(req_tvalid && req_tready), "busy beat")
   `BHT_ASSERT(a_out_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "rsp dropped")
   `BHT_ASSERT(a_status_range, clock, reset, rsp_tvalid |-> (rsp_tuser <= ST_NOT_FOUND), "status")
endmodule
`default_nettype wire

@@ dv/bucketed_hash_table_insert_search_tb.sv @@
`default_nettype none
module bucketed_hash_table_insert_search_tb;
   import bht_pkg::*;

   localparam int NBLK  = 32;
   localparam int NSLOT = 16;

   typedef struct {
      logic [2:0]  status;
      logic [4:0]  blk;
      logic [3:0]  slot;
      logic [63:0] nf;
      logic [47:0] nr;
   } outcome_type;

   class hash_table_scoreboard;
      bit          occupied[NBLK*NSLOT];
      logic [51:0] stored_key[NBLK*NSLOT];
      logic [63:0] stored_nf[NBLK*NSLOT];
      logic [47:0] stored_nr[NBLK*NSLOT];
      logic [5:0]  modulus = 6'd23;
      logic [5:0]  blocks = 6'd26;
      outcome_type awaited[$];
      int          errors = 0;
      int          seen[5] = '{default: 0};

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         if (idx == REG_MODULUS) modulus = val[5:0];
         else if (idx == REG_BLOCKS) blocks = val[5:0];
      endfunction

      function int nib(logic [51:0] k, int d);
         return int'(k[4*(DIGITS-1-d) +: 4]);
      endfunction

      function int four_num(logic [51:0] k, int a, int b, int c, int e);
         return nib(k, a)*1000 + nib(k, b)*100 + nib(k, c)*10 + nib(k, e);
      endfunction

      // walk the probe ring, updating the table copy on insert
      function void note_request(logic kind, logic [51:0] k, logic [63:0] nf,
                                 logic [47:0] nr);
         outcome_type o;
         int ring, m, start, b, s, at;
         bit done;
         ring = (blocks == 0) ? 1 : (blocks > NBLK) ? NBLK : int'(blocks);
         m = (modulus == 0) ? 1 : int'(modulus);
         start = ((four_num(k, 4, 5, 6, 7) + four_num(k, 3, 2, 1, 0) +
                   four_num(k, 11, 10, 9, 8)) % m) % ring;
         o = '{(kind == REQ_SEARCH) ? ST_NOT_FOUND : ST_FULL, 0, 0, 0, 0};
         b = start;
         done = 0;
         do begin
            for (s = 0; s < NSLOT && !done; s++) begin
               at = b*NSLOT + s;
               if (occupied[at]) begin
                  if (stored_key[at] == k) begin
                     o.blk = b[4:0];
                     o.slot = s[3:0];
                     if (kind == REQ_SEARCH) begin
                        o.status = ST_FOUND;
                        o.nf = stored_nf[at];
                        o.nr = stored_nr[at];
                     end else begin
                        o.status = ST_PRESENT;
                     end
                     done = 1;
                  end
               end else begin
                  if (kind == REQ_SEARCH) begin
                     o.status = ST_NOT_FOUND;
                  end else begin
                     occupied[at] = 1;
                     stored_key[at] = k;
                     stored_nf[at] = nf;
                     stored_nr[at] = nr;
                     o.status = ST_INSERTED;
                     o.blk = b[4:0];
                     o.slot = s[3:0];
                  end
                  done = 1;
               end
            end
            b = (b + 1) % ring;
         end while (!done && b != start);
         awaited.push_back(o);
      endfunction

      function void check_result(logic [2:0] st, logic [4:0] blk, logic [3:0] slot,
                                 logic [63:0] nf, logic [47:0] nr);
         outcome_type o;
         if (awaited.size() == 0) begin
            $error("unexpected response beat, status %0d", st);
            errors++;
            return;
         end
         o = awaited.pop_front();
         if (st < 5) seen[st]++;
         if (st !== o.status) begin
            $error("status: expected %0d, got %0d", o.status, st); errors++;
         end
         if (blk !== o.blk) begin
            $error("block_index: expected %0d, got %0d", o.blk, blk); errors++;
         end
         if (slot !== o.slot) begin
            $error("slot_index: expected %0d, got %0d", o.slot, slot); errors++;
         end
         if (nf !== o.nf) begin
            $error("found_name_first: expected %h, got %h", o.nf, nf); errors++;
         end
         if (nr !== o.nr) begin
            $error("found_name_rest: expected %h, got %h", o.nr, nr); errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;  // key_bcd, name_first, name_rest
   logic         req_tuser = 0;   // req_type
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;       // block_index, slot_index, found names
   logic [2:0]   rsp_tuser;       // status
   logic         csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   hash_table_scoreboard table_sb = new();
   int send_idle_pct = 16, recv_idle_pct = 56;
   int hold_asked = 0, hold_taken = 0, hold_left = 0;
   int sent = 0;
   logic [51:0] key_pool[$];

   bucketed_hash_table_insert_search i_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      #(12 * 3_000_000);
      $display("bucketed_hash_table_insert_search regression: fail");
      $finish;
   end

   // response side: check beats, random ready, one long hold-off on request
   always @(posedge clock) begin
      logic [127:0] d;
      d = rsp_tdata;
      if (!reset && rsp_tvalid && rsp_tready)
         table_sb.check_result(rsp_tuser, d[4:0], d[8:5], d[72:9], d[120:73]);
      if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic logic [51:0] make_key(bit decimal);
      logic [51:0] k;
      for (int i = 0; i < 13; i++)
         k[4*i +: 4] = decimal ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 15));
      return k;
   endfunction

   task automatic send_req(logic kind, logic [51:0] k, logic [63:0] nf, logic [47:0] nr);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, nr, nf, k};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      table_sb.note_request(kind, k, nf, nr);
      sent++;
      if (sent == 300) begin
         send_idle_pct = 56; recv_idle_pct = 16;
      end else if (sent == 600) begin
         send_idle_pct = 0; recv_idle_pct = 0;
      end
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx[0], 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      table_sb.write_reg(idx, val);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (table_sb.awaited.size() > 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      int r;
      key_pool.delete();
      for (int i = 0; i < 20; i++) key_pool.push_back(make_key($urandom_range(0, 3) != 0));
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            send_req(REQ_INSERT, key_pool[$urandom_range(0, 19)],
                     {$urandom, $urandom}, {16'($urandom), $urandom});
         else if (r < 80)
            send_req(REQ_SEARCH, key_pool[$urandom_range(0, 19)],
                     {$urandom, $urandom}, {16'($urandom), $urandom});
         else if (r < 90)
            send_req(REQ_SEARCH, make_key(0), '0, '0);
         else
            send_req(REQ_INSERT, make_key(0), {$urandom, $urandom},
                     {16'($urandom), $urandom});
      end
   endtask

   initial begin
      int mods[9] = '{1, 0, 63, 32, 5, 23, 32, 17, 2};
      int blks[9] = '{1, 0, 63, 32, 3, 26, 7, 32, 50};
      int cnts[9] = '{60, 40, 150, 150, 80, 100, 80, 150, 70};
      logic [51:0] odd_key;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: key extremes, name extremes, hit/miss/duplicate
      odd_key = 52'h0123_ABCD_EF98_7;
      send_req(REQ_INSERT, '0, '1, '1);
      send_req(REQ_INSERT, '1, '0, '0);
      send_req(REQ_INSERT, '0, 64'h5555, 48'h1);
      send_req(REQ_SEARCH, '0, '0, '0);
      send_req(REQ_SEARCH, '1, '1, '1);
      send_req(REQ_SEARCH, 52'h1234_5678_9012_3, '0, '0);
      send_req(REQ_INSERT, odd_key, 64'h4142_4344_4546_4748, 48'h494a_4b4c_4d4e);
      send_req(REQ_SEARCH, odd_key, '0, '0);
      send_req(REQ_INSERT, 52'h9999_9999_9999_9, {$urandom, $urandom}, 48'hffff_0000_ffff);
      send_req(REQ_SEARCH, 52'h9999_9999_9999_9, '0, '0);
      send_req(REQ_INSERT, 52'h0000_0000_0000_9, 64'h1, 48'h8000_0000_0000);
      send_req(REQ_SEARCH, 52'h0000_0000_0000_9, '0, '0);
      drain();
      send_req(REQ_SEARCH, odd_key, '0, '0);

      for (int p = 0; p < 9; p++) begin
         drain();
         csr_write(REG_MODULUS, {$urandom} & 32'hffff_ffc0 | mods[p]);
         csr_write(REG_BLOCKS, blks[p]);
         if (p == 3) hold_asked++;
         random_phase(cnts[p]);
      end

      drain();
      repeat (50) @(posedge clock);
      $display("requests: %0d; inserted %0d, duplicate %0d, full %0d, found %0d, missed %0d",
               sent, table_sb.seen[ST_INSERTED], table_sb.seen[ST_PRESENT],
               table_sb.seen[ST_FULL], table_sb.seen[ST_FOUND], table_sb.seen[ST_NOT_FOUND]);
      $display("ring sizes 0 to 63 and moduli 0 to 63 were exercised, one long response stall");
      if (table_sb.errors == 0 && table_sb.awaited.size() == 0)
         $display("bucketed_hash_table_insert_search regression: pass");
      else
         $display("bucketed_hash_table_insert_search regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
